// File: hw/rtl/anc_pkg.sv
// Shared types and constants of the alarm next-trigger calculator.
package anc_pkg;

  localparam int unsigned SecsPerDay = 86400;
  localparam logic [32:0] TrigMax = 33'h1_FFFF_FFFF;
  localparam logic [4:0] WeekLast = 5'd13;
  localparam logic [4:0] MonthLast = 5'd23;
  localparam logic [16:0] DefaultPeriod = 17'd60;
  localparam logic [11:0] YearMin = 12'd1970;
  localparam logic [11:0] YearMax = 12'd2100;
  // ceil(2^36 / 675); exact floor division of any 26-bit value by 675.
  localparam logic [26:0] DayRecip = 27'd101806633;

  typedef enum logic [2:0] {
    KIND_ONCE     = 3'd0,
    KIND_DAILY    = 3'd1,
    KIND_WEEKLY   = 3'd2,
    KIND_MONTHLY  = 3'd3,
    KIND_INTERVAL = 3'd4
  } kind_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DIV, ST_PREP, ST_ODAYS, ST_OMUL, ST_WEEK, ST_YD, ST_YC,
    ST_MD0, ST_MSET, ST_MLEN, ST_MDAYS, ST_MMUL, ST_MCHK, ST_MNEXT, ST_FIN
  } state_e;

  typedef enum logic [3:0] {
    CMD_NONE, CMD_LOAD, CMD_DIV, CMD_PREP, CMD_DAYS, CMD_DYEAR, CMD_DJAN,
    CMD_YSTEP, CMD_MSET, CMD_MUL, CMD_MCHK, CMD_MNEXT, CMD_WEEK, CMD_FIN
  } cmd_e;

  typedef struct packed {
    cmd_e op;
    logic in_ready;
  } ctrl_t;

  typedef struct packed {
    logic       en;
    logic [2:0] kind;
    logic       div_last;
    logic       y_more;
    logic       week_hit;
    logic       week_last;
    logic       mon_ok;
    logic       t_after;
    logic       mon_last;
    logic       out_free;
  } stat_t;

endpackage

// File: hw/rtl/alarm_next_trigger_calc.sv
// Top level of the alarm next-trigger calculator.
//
//   channel  | dir | handshake                      | payload
//   s_axis   | in  | s_axis_tvalid_i/s_axis_tready_o | tdata alarm fields, tuser alarm_kind
//   m_axis   | out | m_axis_tvalid_o/m_axis_tready_i | tdata trigger time, still_enabled
//
// One item at a time: a load step, the reciprocal day divider (quotient, then remainder),
// a setup step, then per kind: daily, interval and disabled go to the result step, one-shot
// reckons its days and time first, weekly steps day by day, monthly steps the year (one or
// two steps), places the month and searches month by month (24 months at most), then the
// result step. The result step waits while an untaken result blocks the output register.
// Reset clears the sequencer and result valid. A stalled result holds in the output register
// while the next item is taken in.
module alarm_next_trigger_calc (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // tdata from bit 0: alarm_enabled, year, month, day, hour, minute, second,
  // weekday_mask, interval length, prior_trigger, now_seconds, zero fill
  input  logic [135:0] s_axis_tdata_i,
  // tuser: alarm_kind
  input  logic [2:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // tdata from bit 0: trigger time, still_enabled, zero fill
  output logic [39:0]  m_axis_tdata_o
);

  anc_pkg::ctrl_t ctrl;
  anc_pkg::stat_t stat;

  anc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  anc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .in_data_i   (s_axis_tdata_i),
    .in_user_i   (s_axis_tuser_i),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_data_o  (m_axis_tdata_o),
    .stat_o      (stat)
  );

  assign s_axis_tready_o = ctrl.in_ready;

endmodule

// File: hw/rtl/anc_ctrl.sv
// Sequencer of the alarm next-trigger calculator.
module anc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  anc_pkg::stat_t stat_i,
  output anc_pkg::ctrl_t ctrl_o
);

  anc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= anc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ctrl_o.op = anc_pkg::CMD_NONE;
    ctrl_o.in_ready = 1'b0;
    case (state_q)
      anc_pkg::ST_IDLE: begin
        ctrl_o.in_ready = 1'b1;
        if (in_valid_i) begin
          ctrl_o.op = anc_pkg::CMD_LOAD;
          state_d = anc_pkg::ST_DIV;
        end
      end
      anc_pkg::ST_DIV: begin
        ctrl_o.op = anc_pkg::CMD_DIV;
        if (stat_i.div_last) state_d = anc_pkg::ST_PREP;
      end
      anc_pkg::ST_PREP: begin
        ctrl_o.op = anc_pkg::CMD_PREP;
        if (!stat_i.en) begin
          state_d = anc_pkg::ST_FIN;
        end else begin
          case (stat_i.kind)
            anc_pkg::KIND_ONCE:    state_d = anc_pkg::ST_ODAYS;
            anc_pkg::KIND_WEEKLY:  state_d = anc_pkg::ST_WEEK;
            anc_pkg::KIND_MONTHLY: state_d = anc_pkg::ST_YD;
            default:               state_d = anc_pkg::ST_FIN;
          endcase
        end
      end
      anc_pkg::ST_ODAYS: begin
        ctrl_o.op = anc_pkg::CMD_DAYS;
        state_d = anc_pkg::ST_OMUL;
      end
      anc_pkg::ST_OMUL: begin
        ctrl_o.op = anc_pkg::CMD_MUL;
        state_d = anc_pkg::ST_FIN;
      end
      anc_pkg::ST_WEEK: begin
        ctrl_o.op = anc_pkg::CMD_WEEK;
        if (stat_i.week_hit || stat_i.week_last) state_d = anc_pkg::ST_FIN;
      end
      anc_pkg::ST_YD: begin
        ctrl_o.op = anc_pkg::CMD_DYEAR;
        state_d = anc_pkg::ST_YC;
      end
      anc_pkg::ST_YC: begin
        ctrl_o.op = anc_pkg::CMD_YSTEP;
        state_d = stat_i.y_more ? anc_pkg::ST_YD : anc_pkg::ST_MD0;
      end
      anc_pkg::ST_MD0: begin
        ctrl_o.op = anc_pkg::CMD_DJAN;
        state_d = anc_pkg::ST_MSET;
      end
      anc_pkg::ST_MSET: begin
        ctrl_o.op = anc_pkg::CMD_MSET;
        state_d = anc_pkg::ST_MLEN;
      end
      anc_pkg::ST_MLEN: begin
        state_d = stat_i.mon_ok ? anc_pkg::ST_MDAYS : anc_pkg::ST_MNEXT;
      end
      anc_pkg::ST_MDAYS: begin
        ctrl_o.op = anc_pkg::CMD_DAYS;
        state_d = anc_pkg::ST_MMUL;
      end
      anc_pkg::ST_MMUL: begin
        ctrl_o.op = anc_pkg::CMD_MUL;
        state_d = anc_pkg::ST_MCHK;
      end
      anc_pkg::ST_MCHK: begin
        ctrl_o.op = anc_pkg::CMD_MCHK;
        state_d = stat_i.t_after ? anc_pkg::ST_FIN : anc_pkg::ST_MNEXT;
      end
      anc_pkg::ST_MNEXT: begin
        ctrl_o.op = anc_pkg::CMD_MNEXT;
        state_d = stat_i.mon_last ? anc_pkg::ST_FIN : anc_pkg::ST_MLEN;
      end
      anc_pkg::ST_FIN: begin
        if (stat_i.out_free) begin
          ctrl_o.op = anc_pkg::CMD_FIN;
          state_d = anc_pkg::ST_IDLE;
        end
      end
      default: state_d = anc_pkg::ST_IDLE;
    endcase
  end

endmodule

// File: hw/rtl/anc_dp.sv
// Datapath of the alarm next-trigger calculator: divider, calendar unit and result register.
module anc_dp (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  anc_pkg::ctrl_t ctrl_i,
  input  logic [135:0]   in_data_i,
  input  logic [2:0]     in_user_i,
  input  logic           out_ready_i,
  output logic           out_valid_o,
  output logic [39:0]    out_data_o,
  output anc_pkg::stat_t stat_o
);

  function automatic logic is_leap(logic [11:0] y);
    logic [24:0] p100;
    logic [13:0] p400;
    logic [11:0] r100;
    logic [11:0] r400;
    p100 = 25'(y) * 25'd5243;
    p400 = 14'(y[11:4]) * 14'd41;
    r100 = y - 12'(p100[24:19]) * 12'd100;
    r400 = y - 12'(p400[13:10]) * 12'd400;
    return ((y[1:0] == 2'd0) && (r100 != 12'd0)) || (r400 == 12'd0);
  endfunction

  function automatic logic [8:0] cum_days(logic [3:0] m);
    case (m)
      4'd1:  return 9'd0;
      4'd2:  return 9'd31;
      4'd3:  return 9'd59;
      4'd4:  return 9'd90;
      4'd5:  return 9'd120;
      4'd6:  return 9'd151;
      4'd7:  return 9'd181;
      4'd8:  return 9'd212;
      4'd9:  return 9'd243;
      4'd10: return 9'd273;
      4'd11: return 9'd304;
      4'd12: return 9'd334;
      default: return 9'd0;
    endcase
  endfunction

  function automatic logic [4:0] month_len(logic [3:0] m, logic lp);
    case (m)
      4'd4, 4'd6, 4'd9, 4'd11: return 5'd30;
      4'd2: return lp ? 5'd29 : 5'd28;
      default: return 5'd31;
    endcase
  endfunction

  // Days since 1970-01-01 for a year of at least 1970; the day may run off the month.
  function automatic logic signed [19:0] civil_days(logic [11:0] y, logic [3:0] m,
                                                    logic [4:0] d);
    logic [11:0] yy;
    logic [24:0] p100;
    logic [13:0] p400;
    logic [22:0] acc;
    logic [22:0] res;
    yy = y - 12'd1;
    p100 = 25'(yy) * 25'd5243;
    p400 = 14'(yy[11:4]) * 14'd41;
    acc = 23'(yy) * 23'd365 + 23'(yy[11:2]) - 23'(p100[24:19]) + 23'(p400[13:10])
        + 23'(cum_days(m)) + 23'(((m > 4'd2) && is_leap(y)) ? 1'b1 : 1'b0) + 23'(d);
    res = acc - 23'd719163;
    return $signed(res[19:0]);
  endfunction

  function automatic logic [32:0] sat33(logic [38:0] v);
    return (v > 39'(anc_pkg::TrigMax)) ? anc_pkg::TrigMax : v[32:0];
  endfunction

  // Latched item.
  logic [2:0]  kind_q;
  logic        en_q;
  logic [11:0] year_q;
  logic [3:0]  month_q;
  logic [4:0]  day_q;
  logic [4:0]  hour_q;
  logic [5:0]  minute_q;
  logic [5:0]  second_q;
  logic [6:0]  mask_q;
  logic [16:0] per_q;
  logic [32:0] prior_q;
  logic [32:0] now_q;

  logic [16:0] rem_q;
  logic [16:0] quo_q;
  logic [4:0]  cnt_q;
  logic [16:0] tod_q;
  logic [35:0] wt_q;
  logic [2:0]  wd_q;
  logic [11:0] cy_q;
  logic [3:0]  cm_q;
  logic [4:0]  cd_q;
  logic signed [19:0] days_q;
  logic signed [38:0] t_q;
  logic        found_q;
  logic        out_valid_q;
  logic [32:0] out_trig_q;
  logic        out_keep_q;

  logic [52:0] quo_p;
  logic [35:0] day_base;
  logic [32:0] div_rem;
  logic [16:0] tod;
  logic [17:0] wd_x;
  logic [35:0] wd_p;
  logic [24:0] yg_p;
  logic [11:0] d_y;
  logic [3:0]  d_m;
  logic [4:0]  d_d;
  logic signed [19:0] d_res;
  logic        cy_leap;
  logic [19:0] doy_w;
  logic [8:0]  doy;
  logic [3:0]  mset;
  logic signed [38:0] now_s;
  logic        t_after;
  logic        week_hit;
  logic [32:0] res_trig;
  logic        res_keep;
  logic [35:0] daily_t;
  logic [16:0] period;

  // Since 86400 = 128 * 675, the day number is (now >> 7) / 675 by reciprocal
  // multiplication; the remainder follows in the next cycle.
  assign quo_p = 53'(now_q[32:7]) * 53'(anc_pkg::DayRecip);
  assign day_base = 36'(quo_q) * 36'(anc_pkg::SecsPerDay);
  assign div_rem = now_q - day_base[32:0];
  assign tod = 17'(hour_q) * 17'd3600 + 17'(minute_q) * 17'd60 + 17'(second_q);
  assign wd_x = 18'(quo_q) + 18'd3;
  assign wd_p = 36'(wd_x) * 36'd149797;
  assign yg_p = 25'(quo_q) * 25'd179;
  assign cy_leap = is_leap(cy_q);
  assign now_s = $signed({6'd0, now_q});
  assign t_after = t_q > now_s;
  assign week_hit = mask_q[wd_q] && (wt_q > 36'(now_q));
  assign doy_w = 20'(quo_q) - days_q;
  assign doy = doy_w[8:0];

  always_comb begin
    d_y = cy_q;
    d_m = cm_q;
    d_d = cd_q;
    if (ctrl_i.op == anc_pkg::CMD_DYEAR) begin
      d_y = cy_q + 12'd1;
      d_m = 4'd1;
      d_d = 5'd1;
    end else if (ctrl_i.op == anc_pkg::CMD_DJAN) begin
      d_m = 4'd1;
      d_d = 5'd1;
    end
  end
  assign d_res = civil_days(d_y, d_m, d_d);

  always_comb begin
    mset = 4'd1;
    for (int i = 2; i <= 12; i++) begin
      if (doy >= cum_days(4'(i)) + 9'((i > 2) && cy_leap)) mset = mset + 4'd1;
    end
  end

  always_comb begin
    daily_t = (wt_q <= 36'(now_q)) ? wt_q + 36'(anc_pkg::SecsPerDay) : wt_q;
    period = (per_q == 17'd0) ? anc_pkg::DefaultPeriod : per_q;
    res_trig = 33'd0;
    res_keep = 1'b1;
    if (!en_q) begin
      res_keep = 1'b0;
    end else begin
      case (kind_q)
        anc_pkg::KIND_ONCE: begin
          res_keep = t_after;
          res_trig = t_after ? sat33(t_q) : 33'd0;
        end
        anc_pkg::KIND_DAILY: res_trig = sat33(39'(daily_t));
        anc_pkg::KIND_WEEKLY, anc_pkg::KIND_MONTHLY: begin
          res_trig = found_q ? sat33(t_q) : 33'd0;
        end
        anc_pkg::KIND_INTERVAL: begin
          if ((prior_q == 33'd0) || (prior_q <= now_q)) begin
            res_trig = sat33(39'(now_q) + 39'(period));
          end else begin
            res_trig = prior_q;
          end
        end
        default: res_trig = prior_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (ctrl_i.op)
      anc_pkg::CMD_LOAD: begin
        kind_q   <= in_user_i;
        en_q     <= in_data_i[0];
        year_q   <= in_data_i[12:1];
        month_q  <= in_data_i[16:13];
        day_q    <= in_data_i[21:17];
        hour_q   <= in_data_i[26:22];
        minute_q <= in_data_i[32:27];
        second_q <= in_data_i[38:33];
        mask_q   <= in_data_i[45:39];
        per_q    <= in_data_i[62:46];
        prior_q  <= in_data_i[95:63];
        now_q    <= in_data_i[128:96];
        cnt_q    <= 5'd1;
        found_q  <= 1'b0;
      end
      anc_pkg::CMD_DIV: begin
        if (cnt_q != 5'd0) begin
          quo_q <= quo_p[52:36];
        end else begin
          rem_q <= div_rem[16:0];
        end
        cnt_q <= cnt_q - 5'd1;
      end
      anc_pkg::CMD_PREP: begin
        tod_q <= tod;
        wt_q  <= 36'(now_q) - 36'(rem_q) + 36'(tod);
        wd_q  <= 3'(wd_x - 18'(wd_p[35:20]) * 18'd7);
        cnt_q <= 5'd0;
        if (kind_q == anc_pkg::KIND_ONCE) begin
          cy_q <= (year_q < anc_pkg::YearMin) ? anc_pkg::YearMin :
                  (year_q > anc_pkg::YearMax) ? anc_pkg::YearMax : year_q;
          cm_q <= (month_q < 4'd1) ? 4'd1 : (month_q > 4'd12) ? 4'd12 : month_q;
          cd_q <= day_q;
        end else begin
          cy_q <= anc_pkg::YearMin + 12'(yg_p[24:16]);
          cm_q <= 4'd1;
          cd_q <= (day_q < 5'd1) ? 5'd1 : day_q;
        end
      end
      anc_pkg::CMD_DAYS, anc_pkg::CMD_DYEAR, anc_pkg::CMD_DJAN: days_q <= d_res;
      anc_pkg::CMD_YSTEP: begin
        if (days_q <= $signed({3'd0, quo_q})) cy_q <= cy_q + 12'd1;
      end
      anc_pkg::CMD_MSET: begin
        cm_q  <= mset;
        cnt_q <= 5'd0;
      end
      anc_pkg::CMD_MUL: begin
        t_q <= 39'(days_q) * 39'sd86400 + $signed({22'd0, tod_q});
      end
      anc_pkg::CMD_MCHK: found_q <= t_after;
      anc_pkg::CMD_MNEXT: begin
        cnt_q <= cnt_q + 5'd1;
        if (cm_q == 4'd12) begin
          cm_q <= 4'd1;
          cy_q <= cy_q + 12'd1;
        end else begin
          cm_q <= cm_q + 4'd1;
        end
      end
      anc_pkg::CMD_WEEK: begin
        if (week_hit) begin
          t_q     <= $signed(39'(wt_q));
          found_q <= 1'b1;
        end
        wt_q  <= wt_q + 36'(anc_pkg::SecsPerDay);
        wd_q  <= (wd_q == 3'd6) ? 3'd0 : wd_q + 3'd1;
        cnt_q <= cnt_q + 5'd1;
      end
      anc_pkg::CMD_FIN: begin
        out_trig_q <= res_trig;
        out_keep_q <= res_keep;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.op == anc_pkg::CMD_FIN) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = {6'd0, out_keep_q, out_trig_q};

  assign stat_o.en = en_q;
  assign stat_o.kind = kind_q;
  assign stat_o.div_last = cnt_q == 5'd0;
  assign stat_o.y_more = days_q <= $signed({3'd0, quo_q});
  assign stat_o.week_hit = week_hit;
  assign stat_o.week_last = cnt_q == anc_pkg::WeekLast;
  assign stat_o.mon_ok = cd_q <= month_len(cm_q, cy_leap);
  assign stat_o.t_after = t_after;
  assign stat_o.mon_last = cnt_q == anc_pkg::MonthLast;
  assign stat_o.out_free = !out_valid_q || out_ready_i;

`ifndef SYNTHESIS
  a_fin_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.op == anc_pkg::CMD_FIN) |-> (!out_valid_q || out_ready_i))
    else $error("result written over an untaken result");
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.op == anc_pkg::CMD_DIV && cnt_q == 5'd0)
      |=> (rem_q < 17'(anc_pkg::SecsPerDay)))
    else $error("day remainder out of range");
  a_wd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.op == anc_pkg::CMD_WEEK) |-> (wd_q <= 3'd6))
    else $error("weekday code out of range");
  a_month_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.op == anc_pkg::CMD_MNEXT) |=> (cm_q >= 4'd1 && cm_q <= 4'd12))
    else $error("month out of range in search");
`endif

endmodule

// File: tb/alarm_next_trigger_calc_test.sv
// Testbench of the alarm next-trigger calculator: directed and random alarms vs. a predictor.
`timescale 1ns / 1ps

module alarm_next_trigger_calc_test;

  localparam int unsigned CYCLE_LIMIT = 1200000;

  typedef struct packed {
    logic [2:0]  kind;
    logic        enabled;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [6:0]  wmask;
    logic [16:0] period;
    logic [32:0] prior;
    logic [32:0] now;
  } alarm_t;

  typedef struct packed {
    logic        keep;
    logic [32:0] trigger;
  } trigger_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  // tdata from bit 0: alarm_enabled, year, month, day, hour, minute, second,
  // weekday_mask, interval length, prior_trigger, now_seconds, zero fill
  logic [135:0] s_axis_tdata_i = '0;
  // tuser: alarm_kind
  logic [2:0]   s_axis_tuser_i = '0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  // tdata from bit 0: trigger time, still_enabled, zero fill
  logic [39:0]  m_axis_tdata_o;

  trigger_t    pending_triggers[$];
  int unsigned error_count = 0;
  int unsigned sent_count = 0;
  int unsigned checked_count = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned kind_seen[8];

  alarm_next_trigger_calc dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i(s_axis_tdata_i),
    .s_axis_tuser_i(s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o(m_axis_tdata_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic bit leap_year(longint y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  // Day number since the epoch of a civil date; the day may lie outside the month.
  function automatic longint epoch_day(longint y, longint m, longint d);
    longint yy, era, yoe, mp, doy;
    yy  = (m <= 2) ? y - 1 : y;
    era = yy / 400;
    yoe = yy - era * 400;
    mp  = (m > 2) ? m - 3 : m + 9;
    doy = (153 * mp + 2) / 5 + d - 1;
    return era * 146097 + yoe * 365 + yoe / 4 - yoe / 100 + doy - 719468;
  endfunction

  function automatic logic [32:0] clip_trigger(longint v);
    if (v < 0) return '0;
    if (v > longint'(anc_pkg::TrigMax)) return anc_pkg::TrigMax;
    return v[32:0];
  endfunction

  function automatic trigger_t next_occurrence(alarm_t a);
    trigger_t r;
    longint now, tod, today, t, y, m, dn, want, len, z, era, doe, yoe, doy, mp, cy, cm, idx;
    r.trigger = '0;
    r.keep = 1'b1;
    now = longint'(a.now);
    tod = a.hour * 3600 + a.minute * 60 + a.second;
    today = now / 86400;
    if (!a.enabled) begin
      r.keep = 1'b0;
    end else begin
      case (a.kind)
        anc_pkg::KIND_ONCE: begin
          y = a.year;
          if (y < 1970) y = 1970;
          if (y > 2100) y = 2100;
          m = a.month;
          if (m < 1) m = 1;
          if (m > 12) m = 12;
          t = epoch_day(y, m, a.day) * 86400 + tod;
          if (t <= now) r.keep = 1'b0;
          else r.trigger = clip_trigger(t);
        end
        anc_pkg::KIND_DAILY: begin
          t = today * 86400 + tod;
          if (t <= now) t += 86400;
          r.trigger = clip_trigger(t);
        end
        anc_pkg::KIND_WEEKLY: begin
          for (int k = 0; k < 14; k++) begin
            dn = today + k;
            t = dn * 86400 + tod;
            if (a.wmask[(dn + 3) % 7] && t > now) begin
              r.trigger = clip_trigger(t);
              break;
            end
          end
        end
        anc_pkg::KIND_MONTHLY: begin
          want = (a.day < 1) ? 1 : a.day;
          z = today + 719468;
          era = z / 146097;
          doe = z - era * 146097;
          yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
          doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
          mp = (5 * doy + 2) / 153;
          cm = (mp < 10) ? mp + 3 : mp - 9;
          cy = yoe + era * 400 + ((cm <= 2) ? 1 : 0);
          for (int k = 0; k < 24; k++) begin
            idx = cm - 1 + k;
            y = cy + idx / 12;
            m = idx % 12 + 1;
            if (m == 4 || m == 6 || m == 9 || m == 11) len = 30;
            else if (m == 2) len = leap_year(y) ? 29 : 28;
            else len = 31;
            if (want <= len) begin
              t = epoch_day(y, m, want) * 86400 + tod;
              if (t > now) begin
                r.trigger = clip_trigger(t);
                break;
              end
            end
          end
        end
        anc_pkg::KIND_INTERVAL: begin
          if (a.prior == 0 || a.prior <= a.now)
            r.trigger = clip_trigger(now + ((a.period == 0) ? 60 : a.period));
          else
            r.trigger = a.prior;
        end
        default: r.trigger = a.prior;
      endcase
    end
    return r;
  endfunction

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver side: random stalls and the result check.
  always @(posedge clk_i) begin
    trigger_t want, got;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = m_axis_tdata_o[33:0];
        checked_count <= checked_count + 1;
        if (pending_triggers.size() == 0) begin
          $error("result with no pending alarm: %h", got);
          error_count++;
        end else begin
          want = pending_triggers.pop_front();
          if (got.trigger !== want.trigger) begin
            $error("next trigger expected %0d actual %0d", want.trigger, got.trigger);
            error_count++;
          end
          if (got.keep !== want.keep) begin
            $error("still_enabled expected %0d actual %0d", want.keep, got.keep);
            error_count++;
          end
        end
      end
      m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_alarm(alarm_t a);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= a.kind;
    s_axis_tdata_i <= {7'b0, a.now, a.prior, a.period, a.wmask, a.second, a.minute,
                       a.hour, a.day, a.month, a.year, a.enabled};
    pending_triggers = {pending_triggers, next_occurrence(a)};
    kind_seen[a.kind]++;
    sent_count++;
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  function automatic alarm_t plain_alarm(logic [2:0] kind, logic [32:0] now);
    alarm_t a;
    a = '0;
    a.kind = kind;
    a.enabled = 1'b1;
    a.year = 12'd2024;
    a.month = 4'd6;
    a.day = 5'd15;
    a.hour = 5'd8;
    a.minute = 6'd30;
    a.wmask = 7'h7F;
    a.now = now;
    return a;
  endfunction

  // Random alarm with in-range fields mostly, raw bits now and then.
  function automatic alarm_t random_alarm();
    alarm_t a;
    a = '0;
    a.kind = ($urandom_range(19) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(4));
    a.enabled = ($urandom_range(9) != 0);
    a.year = ($urandom_range(9) == 0) ? 12'($urandom) : 12'($urandom_range(2100, 1970));
    a.month = ($urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(12, 1));
    a.day = 5'($urandom);
    a.hour = ($urandom_range(9) == 0) ? 5'($urandom) : 5'($urandom_range(23));
    a.minute = ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(59));
    a.second = ($urandom_range(9) == 0) ? 6'($urandom) : 6'($urandom_range(59));
    a.wmask = ($urandom_range(7) == 0) ? 7'(1 << $urandom_range(6)) : 7'($urandom);
    a.period = ($urandom_range(9) == 0) ? 17'($urandom) : 17'($urandom_range(86400));
    case ($urandom_range(5))
      0: a.now = 33'({$urandom, $urandom});
      1: a.now = anc_pkg::TrigMax - 33'($urandom_range(4000000));
      default: a.now = 33'($urandom_range(4102444800, 0));
    endcase
    case ($urandom_range(3))
      0: a.prior = '0;
      1: a.prior = a.now + 33'($urandom_range(200000)) - 33'(100000);
      default: a.prior = 33'({$urandom, $urandom});
    endcase
    return a;
  endfunction

  task automatic test_disabled_and_unused_kinds();
    alarm_t a;
    a = plain_alarm(anc_pkg::KIND_DAILY, 33'd1700000000);
    a.enabled = 1'b0;
    send_alarm(a);
    for (int k = 5; k < 8; k++) begin
      a = plain_alarm(3'(k), 33'd1700000000);
      a.prior = (k == 7) ? anc_pkg::TrigMax : 33'd12345;
      send_alarm(a);
    end
  endtask

  task automatic test_one_shot();
    alarm_t a;
    a = plain_alarm(anc_pkg::KIND_ONCE, 33'd1700000000);
    send_alarm(a);                          // future date
    a.year = 12'd0; send_alarm(a);          // saturates up, in the past
    a.year = 12'hFFF; a.month = 4'd15; a.day = 5'd31; send_alarm(a);
    a.year = 12'd2024; a.month = 4'd0; a.day = 5'd0; send_alarm(a);
    a.hour = 5'd31; a.minute = 6'd63; a.second = 6'd63; send_alarm(a);
    a.now = anc_pkg::TrigMax; send_alarm(a);  // saturated now, always past
  endtask

  task automatic test_daily_weekly();
    alarm_t a;
    a = plain_alarm(anc_pkg::KIND_DAILY, 33'd1700000000);
    send_alarm(a);
    a.hour = 5'd0; a.minute = 6'd0; send_alarm(a);
    a.now = 33'd0; send_alarm(a);
    a.now = anc_pkg::TrigMax; send_alarm(a);  // crosses the top of the range
    a = plain_alarm(anc_pkg::KIND_WEEKLY, 33'd1700000000);
    a.wmask = 7'd0; send_alarm(a);
    a.wmask = 7'h01; send_alarm(a);
    a.wmask = 7'h40; a.hour = 5'd0; send_alarm(a);
    a.wmask = 7'h7F; a.now = anc_pkg::TrigMax - 33'd100; send_alarm(a);
  endtask

  task automatic test_monthly_interval();
    alarm_t a;
    a = plain_alarm(anc_pkg::KIND_MONTHLY, 33'd1706745600);  // early February of a leap year
    a.day = 5'd31; send_alarm(a);
    a.day = 5'd29; send_alarm(a);
    a.day = 5'd0; send_alarm(a);
    a.day = 5'd30; a.now = anc_pkg::TrigMax; send_alarm(a);
    a = plain_alarm(anc_pkg::KIND_INTERVAL, 33'd1700000000);
    a.period = 17'd0; send_alarm(a);
    a.prior = 33'd1700000500; a.period = 17'h1FFFF; send_alarm(a);
    a.prior = 33'd1700000000; send_alarm(a);
    a.prior = '0; a.now = anc_pkg::TrigMax; send_alarm(a);
  endtask

  task automatic test_random_mix(int unsigned count, int unsigned s_pct, int unsigned r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    repeat (count) send_alarm(random_alarm());
  endtask

  initial begin
    int unsigned drain;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_disabled_and_unused_kinds();
    test_one_shot();
    test_daily_weekly();
    test_monthly_interval();
    test_random_mix(480, 13, 75);
    test_random_mix(480, 75, 13);
    test_random_mix(480, 0, 0);
    s_axis_tvalid_i <= 1'b0;
    while (pending_triggers.size() != 0) @(posedge clk_i);
    drain = 0;
    while (drain < 200) begin
      @(posedge clk_i);
      drain++;
    end
    $display("%0d alarms sent, %0d results checked under sender and receiver stalls",
             sent_count, checked_count);
    $display("kinds 0..7 seen: %0d %0d %0d %0d %0d %0d %0d %0d",
             kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3],
             kind_seen[4], kind_seen[5], kind_seen[6], kind_seen[7]);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", error_count);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
